// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the sector cache tag and clock-replacement store.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int ENTRIES_DEFAULT = 64;
	localparam int SECTOR_W        = 32;
	localparam int INDEX_W         = 6;

	// Request function codes.
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;

	// Response kinds.
	localparam logic [1:0] RESP_HIT      = 2'd0;
	localparam logic [1:0] RESP_MISS     = 2'd1;
	localparam logic [1:0] RESP_FLUSH_WB = 2'd2;
	localparam logic [1:0] RESP_FLUSH_NO = 2'd3;

	typedef struct packed {
		logic [1:0]          func;
		logic [SECTOR_W-1:0] sector_number;
	} req_t;

	typedef struct packed {
		logic [1:0]          response_kind;
		logic [INDEX_W-1:0]  entry_index;
		logic                writeback_valid;
		logic [SECTOR_W-1:0] writeback_sector;
		logic                last_item;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_READ_OLD,
		ST_FILL,
		ST_FLUSH,
		ST_FLUSH_NONE
	} state_t;

endpackage

// ===== rtl/sector_cache_clock_replacement.sv =====
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement
// Tag and clock (second-chance) replacement store of a fully associative
// disk-sector cache, with flush write-back reporting.
// ----------------------------------------------------------------------------
//
//  Channel | Valid      | Stall      | Payload | Carries
//  --------+------------+------------+---------+------------------------------
//  request | req_valid  | req_stall  | req     | function and sector number
//  result  | rsp_valid  | rsp_stall  | rsp     | kind, entry, write-back, last
//
// The tag memory is scanned one entry per cycle through its single read port,
// with the compare made in the cycle after the address. A hit ends the scan
// at its entry; a miss scans every entry and fills the lowest free one, or on
// a full store first runs the clock sweep and reads the victim's old tag. A
// flush reports each dirty entry as the scan reaches it, and a flush with
// nothing dirty answers without a scan. The next request is accepted in the
// cycle after the final result is loaded. Reset clears the valid, dirty and
// reference flags and the hand at once, so no clearing pass is needed; the
// tags themselves are not reset. A stalled result holds the scan, and one
// transaction is worked on at a time.
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement import scc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = IW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);

	state_t state_q, state_d;

	// Captured request.
	req_t req_q;

	// Scan pipeline: issue counter, then the registered read stage.
	logic [CW-1:0] issue_q;
	logic          rv_s1;
	logic [IW-1:0] idx_s1;

	// Replacement state.
	logic               inv_found_q;
	logic [IW-1:0]      victim_q;
	logic [IW-1:0]      hand_q;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] dirty_q;
	logic [ENTRIES-1:0] ref_q;

	// Result register.
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Control from the next-state logic.
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          issue_step;
	logic          pipe_hold;
	logic          emit;
	rsp_t          rsp_d;
	logic          wr_en;

	// Tag store outputs.
	logic [SECTOR_W-1:0] tag_s1;
	logic                match_s1;

	logic               out_free;
	logic               hit_s1;
	logic [ENTRIES-1:0] dirty_valid;
	logic [ENTRIES-1:0] dirty_rest;
	logic               flush_last;
	logic               victim_wb;
	logic [IW-1:0]      hand_next;

	scc_tag_store #(
		.ENTRIES (ENTRIES)
	) u_tag_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (victim_q),
		.wr_tag  (req_q.sector_number),
		.key     (req_q.sector_number),
		.tag     (tag_s1),
		.match   (match_s1)
	);

	// The result register may take a new transaction when empty or draining.
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign hit_s1      = rv_s1 && valid_q[idx_s1] && match_s1;
	assign dirty_valid = valid_q & dirty_q;
	// Dirty entries left once the one in the read stage has been reported.
	assign dirty_rest  = dirty_valid & ~({{(ENTRIES-1){1'b0}}, 1'b1} << idx_s1);
	assign flush_last  = (dirty_rest == '0);
	assign victim_wb   = valid_q[victim_q] && dirty_q[victim_q];
	assign hand_next   = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = issue_q[IW-1:0];
		issue_step = 1'b0;
		pipe_hold  = 1'b0;
		emit       = 1'b0;
		rsp_d      = '0;
		wr_en      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.func)
						FUNC_READ, FUNC_WRITE: begin
							state_d = ST_LOOKUP;
						end
						FUNC_FLUSH: begin
							state_d = (|dirty_valid) ? ST_FLUSH : ST_FLUSH_NONE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				if (issue_q != CNT_END) begin
					rd_en      = 1'b1;
					issue_step = 1'b1;
				end
				if (hit_s1) begin
					if (out_free) begin
						emit                = 1'b1;
						rsp_d.response_kind = RESP_HIT;
						rsp_d.entry_index   = INDEX_W'(idx_s1);
						rsp_d.last_item     = 1'b1;
						state_d             = ST_IDLE;
					end else begin
						pipe_hold  = 1'b1;
						rd_en      = 1'b0;
						issue_step = 1'b0;
					end
				end else if (rv_s1 && idx_s1 == LAST_IDX) begin
					// Miss: an invalid entry wins, otherwise the hand sweeps.
					state_d = (inv_found_q || !valid_q[idx_s1]) ? ST_FILL : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (!ref_q[hand_q]) begin
					state_d = ST_READ_OLD;
				end
			end
			ST_READ_OLD: begin
				rd_en   = 1'b1;
				rd_addr = victim_q;
				state_d = ST_FILL;
			end
			ST_FILL: begin
				if (out_free) begin
					emit                   = 1'b1;
					wr_en                  = 1'b1;
					rsp_d.response_kind    = RESP_MISS;
					rsp_d.entry_index      = INDEX_W'(victim_q);
					rsp_d.writeback_valid  = victim_wb;
					rsp_d.writeback_sector = victim_wb ? tag_s1 : '0;
					rsp_d.last_item        = 1'b1;
					state_d                = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (issue_q != CNT_END) begin
					rd_en      = 1'b1;
					issue_step = 1'b1;
				end
				if (rv_s1 && dirty_valid[idx_s1]) begin
					if (out_free) begin
						emit                   = 1'b1;
						rsp_d.response_kind    = RESP_FLUSH_WB;
						rsp_d.entry_index      = INDEX_W'(idx_s1);
						rsp_d.writeback_valid  = 1'b1;
						rsp_d.writeback_sector = tag_s1;
						rsp_d.last_item        = flush_last;
						if (flush_last) begin
							state_d = ST_IDLE;
						end
					end else begin
						pipe_hold  = 1'b1;
						rd_en      = 1'b0;
						issue_step = 1'b0;
					end
				end
			end
			ST_FLUSH_NONE: begin
				if (out_free) begin
					emit                = 1'b1;
					rsp_d.response_kind = RESP_FLUSH_NO;
					rsp_d.last_item     = 1'b1;
					state_d             = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture and the scan read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			rv_s1   <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				issue_q <= '0;
			end else if (issue_step) begin
				issue_q <= issue_q + 1'b1;
			end
			if (!pipe_hold) begin
				rv_s1 <= rd_en && (state_q == ST_LOOKUP || state_q == ST_FLUSH);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (!pipe_hold) begin
			idx_s1 <= issue_q[IW-1:0];
		end
	end

	// Victim selection and the clock hand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_found_q <= 1'b0;
			victim_q    <= '0;
			hand_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					inv_found_q <= 1'b0;
				end
				ST_LOOKUP: begin
					// Remember the lowest invalid entry seen by the scan.
					if (rv_s1 && !valid_q[idx_s1] && !inv_found_q) begin
						inv_found_q <= 1'b1;
						victim_q    <= idx_s1;
					end
				end
				ST_SWEEP: begin
					hand_q <= hand_next;
					if (!ref_q[hand_q]) begin
						victim_q <= hand_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-entry valid, dirty and reference flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			ref_q   <= '0;
		end else begin
			case (state_q)
				ST_LOOKUP: begin
					if (hit_s1 && out_free) begin
						ref_q[idx_s1] <= 1'b1;
						if (req_q.func == FUNC_WRITE) begin
							dirty_q[idx_s1] <= 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					// Second chance: a set reference bit is cleared as the hand passes.
					if (ref_q[hand_q]) begin
						ref_q[hand_q] <= 1'b0;
					end
				end
				ST_FILL: begin
					if (out_free) begin
						valid_q[victim_q] <= 1'b1;
						dirty_q[victim_q] <= (req_q.func == FUNC_WRITE);
						ref_q[victim_q]   <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (emit) begin
						if (flush_last) begin
							valid_q <= '0;
							dirty_q <= '0;
							ref_q   <= '0;
						end else begin
							dirty_q[idx_s1] <= 1'b0;
						end
					end
				end
				ST_FLUSH_NONE: begin
					if (out_free) begin
						valid_q <= '0;
						dirty_q <= '0;
						ref_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register: loads a new transaction only when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== rtl/scc_tag_store.sv =====
// ----------------------------------------------------------------------------
// scc_tag_store
// Sector tag memory with a registered read port and a tag comparator.
// ----------------------------------------------------------------------------
module scc_tag_store import scc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	input  logic                        wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic [SECTOR_W-1:0]         wr_tag,
	input  logic [SECTOR_W-1:0]         key,
	output logic [SECTOR_W-1:0]         tag,
	output logic                        match
);

	logic [SECTOR_W-1:0] mem [ENTRIES];
	logic [SECTOR_W-1:0] rdata_q;

	// Tags are payload: no reset, an entry is only looked at once written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_tag;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign tag   = rdata_q;
	assign match = (rdata_q == key);

endmodule

// ===== test/sector_cache_clock_replacement_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement_tb
// Self-checking bench for the sector cache tag and clock-replacement store.
// Request transactions go in through the valid/stall channel while a
// behavioural copy of the tag store works out every response that each one
// should cause. A monitor compares each response transaction, field by field,
// with the oldest outstanding prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement_tb import scc_pkg::*;;

	localparam int ENTRIES = ENTRIES_DEFAULT;

	// The package names no code for the fourth function value; the block is
	// meant to swallow such a request without any response.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int IDLE_PERCENT   = 36;
	// A miss on a full store scans every tag, sweeps the hand at most one full
	// turn and one step further, and then reads and fills the victim, even with
	// the response side stalling.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 2 * ENTRIES + 16;
	localparam int MAX_PRINTED    = 20;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sector_cache_clock_replacement #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Behavioural copy of the tag store. The flags start cleared and the hand
	// at zero, which is exactly the state the block leaves reset in. Tags are
	// only ever looked at for valid entries, so their initial value is moot.
	// ------------------------------------------------------------------------
	logic [SECTOR_W-1:0] line_tag   [ENTRIES];
	bit                  line_valid [ENTRIES];
	bit                  line_dirty [ENTRIES];
	bit                  line_ref   [ENTRIES];
	int                  hand_pos = 0;

	// Responses still owed by the block, oldest first.
	rsp_t expected_rsp [$];
	rsp_t oldest_expected;

	int error_count    = 0;
	int printed_errors = 0;
	int idle_cycles    = 0;
	// While set, neither side inserts idle cycles.
	bit quiet          = 1'b0;

	function automatic rsp_t make_rsp(input logic [1:0] kind, input logic [INDEX_W-1:0] idx,
			input logic wb, input logic [SECTOR_W-1:0] sector, input logic last);
		rsp_t r;
		r.response_kind    = kind;
		r.entry_index      = idx;
		r.writeback_valid  = wb;
		r.writeback_sector = wb ? sector : '0;
		r.last_item        = last;
		return r;
	endfunction

	// Updates the copy of the store for one accepted request and queues the
	// responses that it should produce.
	function automatic void predict_response(input req_t item);
		rsp_t held;
		bit   held_valid;
		bit   write_back;
		int   victim;

		if (item.func == FUNC_FLUSH) begin
			// Dirty entries are reported in ascending order; each is held back
			// by one step so that the final one can carry the last flag.
			held_valid = 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (line_valid[i] && line_dirty[i]) begin
					if (held_valid)
						expected_rsp.push_back(held);
					held = make_rsp(RESP_FLUSH_WB, i[INDEX_W-1:0], 1'b1, line_tag[i], 1'b0);
					held_valid = 1'b1;
				end
				line_valid[i] = 1'b0;
				line_dirty[i] = 1'b0;
				line_ref[i]   = 1'b0;
			end
			// With nothing dirty there is a single empty report on entry 0.
			if (!held_valid)
				held = make_rsp(RESP_FLUSH_NO, '0, 1'b0, '0, 1'b1);
			held.last_item = 1'b1;
			expected_rsp.push_back(held);
			return;
		end
		if (item.func == FUNC_UNUSED)
			return;

		for (int i = 0; i < ENTRIES; i++) begin
			if (line_valid[i] && line_tag[i] == item.sector_number) begin
				line_ref[i] = 1'b1;
				if (item.func == FUNC_WRITE)
					line_dirty[i] = 1'b1;
				expected_rsp.push_back(make_rsp(RESP_HIT, i[INDEX_W-1:0], 1'b0, '0, 1'b1));
				return;
			end
		end

		// The lowest free entry wins and leaves the hand alone. Only a full
		// store starts the second-chance sweep.
		victim = -1;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (!line_valid[i])
				victim = i;
		while (victim < 0) begin
			if (!line_ref[hand_pos])
				victim = hand_pos;
			else
				line_ref[hand_pos] = 1'b0;
			hand_pos = (hand_pos + 1) % ENTRIES;
		end

		write_back = line_valid[victim] && line_dirty[victim];
		expected_rsp.push_back(make_rsp(RESP_MISS, victim[INDEX_W-1:0], write_back,
				line_tag[victim], 1'b1));
		line_tag[victim]   = item.sector_number;
		line_valid[victim] = 1'b1;
		line_dirty[victim] = (item.func == FUNC_WRITE);
		line_ref[victim]   = 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (printed_errors < MAX_PRINTED) begin
			printed_errors++;
			$display("%0.1f ns: mismatch: %s", $realtime, what);
		end
	endtask

	// ------------------------------------------------------------------------
	// Request side. Valid is left high after a transaction so that a request
	// that follows without a gap is not lowered and raised in the same step;
	// the next call or the pause task decides what valid does next.
	// ------------------------------------------------------------------------
	task automatic send_request(input logic [1:0] func, input logic [SECTOR_W-1:0] sector);
		req_t item;
		int   gap;

		item.func          = func;
		item.sector_number = sector;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < IDLE_PERCENT)
				gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
		predict_response(item);
	endtask

	// Holds the request side off until every outstanding response has arrived.
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: random stall, and the monitor with the watchdog. Both
	// sample at the rising edge, before any of this edge's updates land.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;

			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("unrequested response, kind %0d entry %0d",
							rsp.response_kind, rsp.entry_index));
				end else begin
					oldest_expected = expected_rsp.pop_front();
					if (rsp.response_kind !== oldest_expected.response_kind)
						report_mismatch($sformatf("response_kind got %0d want %0d",
								rsp.response_kind, oldest_expected.response_kind));
					if (rsp.entry_index !== oldest_expected.entry_index)
						report_mismatch($sformatf("entry_index got %0d want %0d",
								rsp.entry_index, oldest_expected.entry_index));
					if (rsp.writeback_valid !== oldest_expected.writeback_valid)
						report_mismatch($sformatf("writeback_valid got %0b want %0b",
								rsp.writeback_valid, oldest_expected.writeback_valid));
					if (rsp.writeback_sector !== oldest_expected.writeback_sector)
						report_mismatch($sformatf("writeback_sector got %h want %h",
								rsp.writeback_sector, oldest_expected.writeback_sector));
					if (rsp.last_item !== oldest_expected.last_item)
						report_mismatch($sformatf("last_item got %0b want %0b",
								rsp.last_item, oldest_expected.last_item));
				end
			end

			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Fresh store: misses into free entries, hits, the all-ones sector, an
	// ignored request, a flush with write-backs and an empty flush.
	task automatic test_directed_basics();
		send_request(FUNC_READ, 32'h0000_0000);
		send_request(FUNC_WRITE, 32'hFFFF_FFFF);
		send_request(FUNC_READ, 32'hFFFF_FFFF);
		send_request(FUNC_WRITE, 32'h0000_0000);
		send_request(FUNC_UNUSED, 32'h5A5A_A5A5);
		send_request(FUNC_READ, 32'h0000_0001);
		send_request(FUNC_WRITE, 32'h8000_0000);
		send_request(FUNC_READ, 32'h8000_0000);
		send_request(FUNC_FLUSH, $urandom());
		send_request(FUNC_FLUSH, 32'hFFFF_FFFF);
		// After a flush the lowest entry is free again.
		send_request(FUNC_READ, 32'h0000_0000);
		send_request(FUNC_UNUSED, 32'hFFFF_FFFF);
		send_request(FUNC_WRITE, 32'h7FFF_FFFF);
		send_request(FUNC_READ, 32'h7FFF_FFFF);
		// Hold off until the store has answered everything.
		wait_for_responses();
		send_request(FUNC_FLUSH, 32'h0000_0000);
	endtask

	// A pool a little larger than the store fills it and then keeps the
	// clock hand sweeping over a mix of referenced and unreferenced entries.
	task automatic test_fill_and_sweep(input int count);
		logic [SECTOR_W-1:0] base;
		logic [SECTOR_W-1:0] sector;
		logic [1:0]          func;

		base = $urandom();
		for (int n = 0; n < count; n++) begin
			// The opening stretch runs with neither side idling.
			quiet = (n < 60);
			sector = ($urandom_range(99) < 10) ? $urandom() : base + $urandom_range(95);
			func   = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
			send_request(func, sector);
		end
		quiet = 1'b0;
	endtask

	// Every entry written and referenced: the next miss sends the hand round
	// a whole turn onto a dirty victim, and the flush reports every entry but the refilled victim.
	task automatic test_full_store_flush();
		logic [SECTOR_W-1:0] base;

		base = $urandom();
		send_request(FUNC_FLUSH, $urandom());
		for (int n = 0; n < ENTRIES; n++)
			send_request(FUNC_WRITE, base + n);
		send_request(FUNC_READ, base + ENTRIES);
		send_request(FUNC_FLUSH, $urandom());
	endtask

	// Everything mixed: flushes, ignored requests, wide and extreme sectors,
	// with a pause halfway through.
	task automatic test_random_mixed(input int count);
		logic [SECTOR_W-1:0] base;
		logic [SECTOR_W-1:0] sector;
		logic [1:0]          func;
		int                  roll;

		base = $urandom();
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 15)
				sector = $urandom();
			else if (roll < 20)
				sector = 32'hFFFF_FFFF;
			else
				sector = base + $urandom_range(71);
			roll = $urandom_range(99);
			if (roll < 4)
				func = FUNC_FLUSH;
			else if (roll < 8)
				func = FUNC_UNUSED;
			else
				func = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
			send_request(func, sector);
			if (n == count / 2)
				wait_for_responses();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_basics();
		test_fill_and_sweep(150);
		test_full_store_flush();
		test_random_mixed(110);

		// Let the last responses drain, then give the block time to show any
		// response that nothing asked for.
		wait_for_responses();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
